>>> rtl/core/tsbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbf_pkg
// Shared types and constants of the telnet-to-serial byte filter.
// ----------------------------------------------------------------------------
package tsbf_pkg;

    // Byte codes
    localparam logic [7:0] IAC_CODE = 8'd255;
    localparam logic [7:0] NL_CODE  = 8'd10;
    localparam logic [7:0] CR_CODE  = 8'd13;
    localparam logic [7:0] MASK7    = 8'h7f;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_OPTIONS_DISABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_TO_CR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CR_ONLY          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEVEN_BIT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_ENABLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK_CODE       = 3'd5;

    // Result actions
    localparam logic ACT_SEND  = 1'b0;
    localparam logic ACT_BREAK = 1'b1;

    // Telnet command parsing phase
    typedef enum logic [1:0] {
        PH_DATA = 2'd0,
        PH_CMD  = 2'd1,
        PH_OPT  = 2'd2
    } phase_t;

    // Configuration register set
    typedef struct packed {
        logic       options_disabled;
        logic       newline_to_cr;
        logic       cr_only;
        logic       seven_bit;
        logic       break_enable;
        logic [7:0] break_code;
    } cfg_t;

endpackage

>>> rtl/core/telnet_to_serial_byte_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_to_serial_byte_filter_core
// Telnet IAC stripping filter that turns a telnet byte stream into serial
// send-byte and send-break actions.
// m_tvalid rises once the byte has passed the two-entry queue and the result register.
// Throughput: one byte per cycle while m_tready stays high, set by the two-entry queue and result register.
// Command, option and dropped newline bytes are consumed without a result.
// Reset (aresetn low, synchronous) clears parser phase, queue, last byte,
// result valid and all configuration registers to zero.
// ----------------------------------------------------------------------------
module telnet_to_serial_byte_filter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [tsbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] in_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tuser    // [0] action
);
    import tsbf_pkg::*;

    cfg_t       cfg_reg;
    logic       f_push_valid;
    logic       f_push_ready;
    logic [7:0] f_push_data;
    logic       q_pop_valid;
    logic       q_pop_ready;
    logic [7:0] q_pop_data;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_OPTIONS_DISABLED: cfg_reg.options_disabled <= cfg_wdata[0];
                REG_NEWLINE_TO_CR:    cfg_reg.newline_to_cr    <= cfg_wdata[0];
                REG_CR_ONLY:          cfg_reg.cr_only          <= cfg_wdata[0];
                REG_SEVEN_BIT:        cfg_reg.seven_bit        <= cfg_wdata[0];
                REG_BREAK_ENABLE:     cfg_reg.break_enable     <= cfg_wdata[0];
                REG_BREAK_CODE:       cfg_reg.break_code       <= cfg_wdata;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    tsbf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data)
    );

    tsbf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_push_valid),
        .push_ready (f_push_ready),
        .push_data  (f_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    tsbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/core/tsbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbf_front
// Accepts raw telnet bytes, strips command sequences and pushes data bytes.
// ----------------------------------------------------------------------------
module tsbf_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  tsbf_pkg::cfg_t cfg,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    output logic           push_valid,
    input  logic           push_ready,
    output logic [7:0]     push_data
);
    import tsbf_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic   is_iac;
    logic   pass;
    logic   accept;

    assign is_iac   = (s_tdata == IAC_CODE);
    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;

    // Next phase of the command parser
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_CMD:  phase_next = is_iac ? PH_DATA : PH_OPT;
                PH_OPT:  phase_next = PH_DATA;
                default: phase_next = (is_iac && !cfg.options_disabled) ? PH_CMD : PH_DATA;
            endcase
        end
    end

    // Decide whether the byte is data for the back end
    always_comb begin
        case (phase_reg)
            PH_CMD:  pass = is_iac;
            PH_OPT:  pass = 1'b0;
            default: pass = !(is_iac && !cfg.options_disabled);
        endcase
    end

    assign push_valid = s_tvalid && pass;
    assign push_data  = s_tdata;

    // Advance the phase on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DATA;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // An option byte is never forwarded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OPT) |-> !push_valid)
        else $error("option byte forwarded");

    // IAC in data phase with stripping on opens a command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_DATA && is_iac && !cfg.options_disabled)
        |=> (phase_reg == PH_CMD))
        else $error("IAC did not open a command");

    // A command byte other than IAC leads to the option phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_CMD && !is_iac) |=> (phase_reg == PH_OPT))
        else $error("command byte not followed by option phase");

endmodule

>>> rtl/core/tsbf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbf_fifo
// Two-entry byte queue between the parser front end and the action back end.
// ----------------------------------------------------------------------------
module tsbf_fifo (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  logic [7:0] push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output logic [7:0] pop_data
);
    import tsbf_pkg::*;

    logic [7:0] slot0_reg;
    logic [7:0] slot1_reg;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = rd_ptr_reg ? slot1_reg : slot0_reg;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed bytes
    always_ff @(posedge aclk) begin
        if (do_push && !wr_ptr_reg) begin
            slot0_reg <= push_data;
        end
        if (do_push && wr_ptr_reg) begin
            slot1_reg <= push_data;
        end
    end

    // Fill count stays within depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue overfilled");

    // Pointers agree with the fill count
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg == 2'd0) || (count_reg == 2'd2)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");

    // A push and pop together leave the count unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && do_pop) |=> $stable(count_reg))
        else $error("queue count moved on push and pop");

endmodule

>>> rtl/core/tsbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbf_back
// Applies break match, newline handling and masking, and holds the result.
// ----------------------------------------------------------------------------
module tsbf_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  tsbf_pkg::cfg_t cfg,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  logic [7:0]     pop_data,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tuser
);
    import tsbf_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_action_reg;
    logic [7:0] last_byte_reg;
    logic [7:0] last_byte_next;
    logic       do_pop;
    logic       is_break;
    logic [7:0] nl_byte;
    logic       drop;
    logic [7:0] sent_byte;

    assign pop_ready = !out_valid_reg || m_tready;
    assign do_pop    = pop_valid && pop_ready;

    // Classify and translate the data byte
    always_comb begin
        is_break  = cfg.break_enable && (pop_data == cfg.break_code);
        nl_byte   = (cfg.newline_to_cr && pop_data == NL_CODE) ? CR_CODE : pop_data;
        drop      = !is_break && cfg.cr_only && (nl_byte == NL_CODE)
                    && (last_byte_reg == CR_CODE);
        sent_byte = cfg.seven_bit ? (nl_byte & MASK7) : nl_byte;
    end

    // Track the last processed byte and the output valid
    always_comb begin
        last_byte_next = last_byte_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (do_pop) begin
            if (drop) begin
                last_byte_next = NL_CODE;
            end else if (!is_break) begin
                last_byte_next = sent_byte;
            end
            if (!drop) begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_byte_reg <= 8'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            last_byte_reg <= last_byte_next;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (do_pop && !drop) begin
            out_action_reg <= is_break ? ACT_BREAK : ACT_SEND;
            out_byte_reg   <= is_break ? 8'd0 : sent_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_action_reg;

    // A break carries a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ACT_BREAK) |-> (m_tdata == 8'd0))
        else $error("break result with nonzero byte");

    // A break leaves the last byte untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && is_break) |=> $stable(last_byte_reg))
        else $error("break changed last byte");

    // A dropped newline produces no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && drop && m_tready) |=> !m_tvalid)
        else $error("dropped newline produced a result");

endmodule
